>>> rtl/mdsd_pkg.sv
// Shared types and constants for the minimum descriptor set distance block.
// Used by mdsd_ctrl, mdsd_datapath and the min_descriptor_set_distance top level.
package mdsd_pkg;

   // Default geometry of the descriptor stores
   localparam int DESCRIPTOR_DIM_DEF  = 128;
   localparam int MAX_DESCRIPTORS_DEF = 4;

   // Fixed field widths
   localparam int ACTION_W  = 2;
   localparam int SLOT_W    = 2;
   localparam int ELEMENT_W = 7;
   localparam int VALUE_W   = 8;
   localparam int COUNT_W   = 3;
   localparam int DIST_W    = 24;
   localparam int SQ_W      = 2 * VALUE_W;

   // Request actions; the fourth code is ignored
   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD_A  = 2'd0,
      ACT_LOAD_B  = 2'd1,
      ACT_COMPUTE = 2'd2
   } action_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic wr_a;      // write request value into set A
      logic wr_b;      // write request value into set B
      logic rd_en;     // read one element pair from both stores
      logic rd_first;  // the read is the first element of a pair
      logic rd_last;   // the read is the last element of a pair
      logic start;     // new compute: reset running minimum
      logic res_load;  // copy running minimum into the result register
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic busy;      // element pipeline still holds work
   } status_type;

endpackage

>>> rtl/mdsd_ctrl.sv
// Controller for the minimum descriptor set distance block: request decode,
// pair and element sequencing, result handshake. Depends on mdsd_pkg.
module mdsd_ctrl #(
   parameter int DESCRIPTOR_DIM  = mdsd_pkg::DESCRIPTOR_DIM_DEF,
   parameter int MAX_DESCRIPTORS = mdsd_pkg::MAX_DESCRIPTORS_DEF,
   localparam int ADDR_W = (MAX_DESCRIPTORS * DESCRIPTOR_DIM > 1) ?
                           $clog2(MAX_DESCRIPTORS * DESCRIPTOR_DIM) : 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [mdsd_pkg::ACTION_W-1:0]   req_action,
   input  logic [mdsd_pkg::SLOT_W-1:0]     req_slot,
   input  logic [mdsd_pkg::ELEMENT_W-1:0]  req_element,
   input  logic [mdsd_pkg::COUNT_W-1:0]    req_count_a,
   input  logic [mdsd_pkg::COUNT_W-1:0]    req_count_b,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_pair_found,
   output mdsd_pkg::cmd_type               cmd,
   input  mdsd_pkg::status_type            status,
   output logic [ADDR_W-1:0]               wr_addr,
   output logic [ADDR_W-1:0]               rd_addr_a,
   output logic [ADDR_W-1:0]               rd_addr_b
);
   import mdsd_pkg::*;

   localparam int IDX_W = (MAX_DESCRIPTORS > 1) ? $clog2(MAX_DESCRIPTORS) : 1;
   localparam int CNT_W = $clog2(MAX_DESCRIPTORS + 1);
   localparam int CMP_W = CNT_W + 1;
   localparam int K_W   = (DESCRIPTOR_DIM > 1) ? $clog2(DESCRIPTOR_DIM) : 1;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [K_W-1:0]   k_ff, k_in;
   logic [CNT_W-1:0] na_ff, na_in;
   logic [CNT_W-1:0] nb_ff, nb_in;
   logic             found_ff, found_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_found_ff, rsp_found_in;

   logic             req_accept;
   action_type       act;
   logic             wr_in_range;
   logic [CNT_W-1:0] na_sat, nb_sat;
   logic             k_last, j_last, i_last;
   logic             drain_done;

   // Decode the request
   assign act         = action_type'(req_action);
   assign req_accept  = req_valid && !req_stall;
   assign wr_in_range = (int'(req_slot) < MAX_DESCRIPTORS) &&
                        (int'(req_element) < DESCRIPTOR_DIM);
   assign wr_addr     = ADDR_W'(int'(req_slot) * DESCRIPTOR_DIM + int'(req_element));

   // Saturate set counts to the store capacity
   always_comb begin
      if (int'(req_count_a) > MAX_DESCRIPTORS) begin
         na_sat = CNT_W'(MAX_DESCRIPTORS);
      end else begin
         na_sat = CNT_W'(req_count_a);
      end
      if (int'(req_count_b) > MAX_DESCRIPTORS) begin
         nb_sat = CNT_W'(MAX_DESCRIPTORS);
      end else begin
         nb_sat = CNT_W'(req_count_b);
      end
   end

   // Sequence position: A index, B index, element index
   assign k_last = (k_ff == K_W'(DESCRIPTOR_DIM - 1));
   assign j_last = ((CMP_W'(j_ff) + CMP_W'(1)) == CMP_W'(nb_ff));
   assign i_last = ((CMP_W'(i_ff) + CMP_W'(1)) == CMP_W'(na_ff));

   assign rd_addr_a = ADDR_W'(int'(i_ff) * DESCRIPTOR_DIM + int'(k_ff));
   assign rd_addr_b = ADDR_W'(int'(j_ff) * DESCRIPTOR_DIM + int'(k_ff));

   // Finish once the pipeline is empty and the result register is free
   assign drain_done = (state_ff == ST_DRAIN) && !status.busy &&
                       (!rsp_valid_ff || !rsp_stall);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && act == ACT_COMPUTE) begin
               if (na_sat == '0 || nb_sat == '0) begin
                  state_in = ST_DRAIN;
               end else begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (k_last && j_last && i_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (drain_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath commands
   always_comb begin
      req_stall    = (state_ff != ST_IDLE);
      cmd          = '0;
      cmd.wr_a     = req_accept && (act == ACT_LOAD_A) && wr_in_range;
      cmd.wr_b     = req_accept && (act == ACT_LOAD_B) && wr_in_range;
      cmd.start    = req_accept && (act == ACT_COMPUTE);
      cmd.rd_en    = (state_ff == ST_RUN);
      cmd.rd_first = (k_ff == '0);
      cmd.rd_last  = k_last;
      cmd.res_load = drain_done;
   end

   // Advance the pair and element counters
   always_comb begin
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      na_in    = na_ff;
      nb_in    = nb_ff;
      found_in = found_ff;
      if (cmd.start) begin
         i_in     = '0;
         j_in     = '0;
         k_in     = '0;
         na_in    = na_sat;
         nb_in    = nb_sat;
         found_in = (na_sat != '0) && (nb_sat != '0);
      end else if (state_ff == ST_RUN) begin
         if (k_last) begin
            k_in = '0;
            if (j_last) begin
               j_in = '0;
               i_in = i_ff + IDX_W'(1);
            end else begin
               j_in = j_ff + IDX_W'(1);
            end
         end else begin
            k_in = k_ff + K_W'(1);
         end
      end
   end

   // Result handshake: load wins over a same-cycle take
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.res_load) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = found_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      na_ff        <= na_in;
      nb_ff        <= nb_in;
      found_ff     <= found_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pair_found = rsp_found_ff;

`ifndef ASSERT_OFF
   a_rd_wr_excl: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> !(cmd.wr_a || cmd.wr_b))
      else $error("store write during compute sweep");

   a_run_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |->
         ((CMP_W'(i_ff) < CMP_W'(na_ff)) && (CMP_W'(j_ff) < CMP_W'(nb_ff))))
      else $error("descriptor index beyond set count");

   a_rsp_from_drain: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DRAIN))
      else $error("response raised outside drain");
`endif

endmodule

>>> rtl/mdsd_datapath.sv
// Datapath for the minimum descriptor set distance block: descriptor stores,
// squared-difference pipeline, early-stop accumulator, running minimum. Depends on mdsd_pkg.
module mdsd_datapath #(
   parameter int DESCRIPTOR_DIM  = mdsd_pkg::DESCRIPTOR_DIM_DEF,
   parameter int MAX_DESCRIPTORS = mdsd_pkg::MAX_DESCRIPTORS_DEF,
   localparam int ADDR_W = (MAX_DESCRIPTORS * DESCRIPTOR_DIM > 1) ?
                           $clog2(MAX_DESCRIPTORS * DESCRIPTOR_DIM) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  mdsd_pkg::cmd_type              cmd,
   output mdsd_pkg::status_type           status,
   input  logic [ADDR_W-1:0]              wr_addr,
   input  logic [ADDR_W-1:0]              rd_addr_a,
   input  logic [ADDR_W-1:0]              rd_addr_b,
   input  logic [mdsd_pkg::VALUE_W-1:0]   req_value,
   input  logic                           csr_write_enable,
   input  logic [mdsd_pkg::DIST_W-1:0]    csr_write_data,
   output logic [mdsd_pkg::DIST_W-1:0]    rsp_min_distance
);
   import mdsd_pkg::*;

   localparam int DEPTH = MAX_DESCRIPTORS * DESCRIPTOR_DIM;

   logic [VALUE_W-1:0] mem_a [DEPTH];
   logic [VALUE_W-1:0] mem_b [DEPTH];

   logic [DIST_W-1:0]  thr_ff;

   // Stage 1: store read data
   logic [VALUE_W-1:0] rd_a_ff, rd_b_ff;
   logic               v1_ff, first1_ff, last1_ff;

   // Stage 2: squared difference
   logic [VALUE_W-1:0] abs_diff;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic               v2_ff, first2_ff, last2_ff;

   // Stage 3: pair accumulator
   logic [DIST_W-1:0]  sum_ff, sum_in;
   logic               open_ff, open_in;
   logic               fold_ff, fold_in;
   logic [DIST_W-1:0]  sum_base;
   logic [DIST_W:0]    sum_add;
   logic [DIST_W-1:0]  sum_sat;
   logic               take, stop;

   // Stage 4: running minimum and result
   logic [DIST_W-1:0]  best_ff, best_in;
   logic [DIST_W-1:0]  res_ff;

   // Threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '1;
      end else if (csr_write_enable) begin
         thr_ff <= csr_write_data;
      end
   end

   // Set A store
   always_ff @(posedge clock) begin
      if (cmd.wr_a) begin
         mem_a[wr_addr] <= req_value;
      end
      if (cmd.rd_en) begin
         rd_a_ff <= mem_a[rd_addr_a];
      end
   end

   // Set B store
   always_ff @(posedge clock) begin
      if (cmd.wr_b) begin
         mem_b[wr_addr] <= req_value;
      end
      if (cmd.rd_en) begin
         rd_b_ff <= mem_b[rd_addr_b];
      end
   end

   // Square the absolute element difference
   always_comb begin
      if (rd_a_ff >= rd_b_ff) begin
         abs_diff = rd_a_ff - rd_b_ff;
      end else begin
         abs_diff = rd_b_ff - rd_a_ff;
      end
      sq_in = SQ_W'(abs_diff) * SQ_W'(abs_diff);
   end

   // Accumulate with saturation; drop elements after an early stop
   always_comb begin
      sum_base = first2_ff ? '0 : sum_ff;
      sum_add  = {1'b0, sum_base} + (DIST_W + 1)'(sq_ff);
      sum_sat  = sum_add[DIST_W] ? '1 : sum_add[DIST_W-1:0];
      stop     = (sum_sat >= thr_ff);
      take     = v2_ff && (first2_ff || open_ff);
      sum_in   = take ? sum_sat : sum_ff;
      open_in  = take ? !stop : open_ff;
      fold_in  = take && (stop || last2_ff);
   end

   // Keep the smallest closed pair sum
   always_comb begin
      best_in = best_ff;
      if (cmd.start) begin
         best_in = '1;
      end else if (fold_ff && (sum_ff < best_ff)) begin
         best_in = sum_ff;
      end
   end

   // Pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         open_ff <= 1'b0;
         fold_ff <= 1'b0;
      end else begin
         v1_ff   <= cmd.rd_en;
         v2_ff   <= v1_ff;
         open_ff <= open_in;
         fold_ff <= fold_in;
      end
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      first1_ff <= cmd.rd_first;
      last1_ff  <= cmd.rd_last;
      first2_ff <= first1_ff;
      last2_ff  <= last1_ff;
      sq_ff     <= sq_in;
      sum_ff    <= sum_in;
      best_ff   <= best_in;
      if (cmd.res_load) begin
         res_ff <= best_ff;
      end
   end

   assign status.busy      = v1_ff || v2_ff || fold_ff;
   assign rsp_min_distance = res_ff;

endmodule

>>> rtl/min_descriptor_set_distance.sv
// The block accepts load requests one per cycle while idle.
// A compute request walks every A-B pair one element per cycle through one read
// port per set store and raises rsp_valid once the pipeline has drained and the
// result register is free, one compute at a time. With an empty set the controller
// skips the sweep and goes to drain; a result still waiting delays either case.
// Synchronous active-high reset clears control state, sets threshold to all ones.
module min_descriptor_set_distance #(
   parameter int DESCRIPTOR_DIM  = mdsd_pkg::DESCRIPTOR_DIM_DEF,
   parameter int MAX_DESCRIPTORS = mdsd_pkg::MAX_DESCRIPTORS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [mdsd_pkg::ACTION_W-1:0]   req_action,
   input  logic [mdsd_pkg::SLOT_W-1:0]     req_slot,
   input  logic [mdsd_pkg::ELEMENT_W-1:0]  req_element,
   input  logic [mdsd_pkg::VALUE_W-1:0]    req_value,
   input  logic [mdsd_pkg::COUNT_W-1:0]    req_count_a,
   input  logic [mdsd_pkg::COUNT_W-1:0]    req_count_b,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [mdsd_pkg::DIST_W-1:0]     rsp_min_distance,
   output logic                            rsp_pair_found,
   input  logic                            csr_write_enable,
   input  logic [mdsd_pkg::DIST_W-1:0]     csr_write_data
);
   import mdsd_pkg::*;

   localparam int ADDR_W = (MAX_DESCRIPTORS * DESCRIPTOR_DIM > 1) ?
                           $clog2(MAX_DESCRIPTORS * DESCRIPTOR_DIM) : 1;

   cmd_type           cmd;
   status_type        status;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr_a;
   logic [ADDR_W-1:0] rd_addr_b;

   // Sequencing and handshakes
   mdsd_ctrl #(
      .DESCRIPTOR_DIM  (DESCRIPTOR_DIM),
      .MAX_DESCRIPTORS (MAX_DESCRIPTORS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_slot       (req_slot),
      .req_element    (req_element),
      .req_count_a    (req_count_a),
      .req_count_b    (req_count_b),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pair_found (rsp_pair_found),
      .cmd            (cmd),
      .status         (status),
      .wr_addr        (wr_addr),
      .rd_addr_a      (rd_addr_a),
      .rd_addr_b      (rd_addr_b)
   );

   // Stores and distance arithmetic
   mdsd_datapath #(
      .DESCRIPTOR_DIM  (DESCRIPTOR_DIM),
      .MAX_DESCRIPTORS (MAX_DESCRIPTORS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .wr_addr          (wr_addr),
      .rd_addr_a        (rd_addr_a),
      .rd_addr_b        (rd_addr_b),
      .req_value        (req_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_min_distance (rsp_min_distance)
   );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Testbench for min_descriptor_set_distance: loads both descriptor sets, runs
// compute requests under several thresholds and checks every result against a
// predictor. Depends on mdsd_pkg and the RTL top level only.

package mdsd_tb_pkg;
   import mdsd_pkg::*;

   localparam int DIM   = DESCRIPTOR_DIM_DEF;
   localparam int SLOTS = MAX_DESCRIPTORS_DEF;
   localparam logic [DIST_W-1:0] DIST_ALL_ONES = '1;

   typedef struct {
      logic [DIST_W-1:0] min_dist;
      logic              found;
   } min_result_type;

   // Mirror of the descriptor stores and threshold; predicts each compute
   class min_distance_scoreboard;
      logic [VALUE_W-1:0] set_a [SLOTS*DIM];
      logic [VALUE_W-1:0] set_b [SLOTS*DIM];
      logic [DIST_W-1:0]  threshold;
      min_result_type     expected_min_q [$];
      int failures, n_loads, n_computes, n_found, n_ignored;

      function new();
         threshold = DIST_ALL_ONES;
         foreach (set_a[i]) begin
            set_a[i] = '0;
            set_b[i] = '0;
         end
         failures   = 0;
         n_loads    = 0;
         n_computes = 0;
         n_found    = 0;
         n_ignored  = 0;
      endfunction

      function void set_threshold(logic [DIST_W-1:0] t);
         threshold = t;
      endfunction

      // Sum squared differences of one pair; stop once the sum reaches the threshold
      function logic [DIST_W-1:0] pair_sq_distance(int ia, int ib);
         int unsigned acc;
         int          diff;
         bit          stop;
         acc  = 0;
         stop = 1'b0;
         for (int k = 0; k < DIM && !stop; k++) begin
            diff = int'(set_a[ia*DIM+k]) - int'(set_b[ib*DIM+k]);
            acc  = acc + int'(diff * diff);
            if (acc > 32'h00FF_FFFF) acc = 32'h00FF_FFFF;
            if (acc >= threshold) stop = 1'b1;
         end
         return acc[DIST_W-1:0];
      endfunction

      // Apply one accepted request; queue the expected minimum on a compute
      function void note_request(logic [ACTION_W-1:0] act, logic [SLOT_W-1:0] slot,
                                 logic [ELEMENT_W-1:0] elem, logic [VALUE_W-1:0] val,
                                 logic [COUNT_W-1:0] ca, logic [COUNT_W-1:0] cb);
         int                na, nb;
         logic [DIST_W-1:0] d;
         min_result_type    want;
         case (act)
            ACT_LOAD_A: begin
               set_a[int'(slot)*DIM + int'(elem)] = val;
               n_loads++;
            end
            ACT_LOAD_B: begin
               set_b[int'(slot)*DIM + int'(elem)] = val;
               n_loads++;
            end
            ACT_COMPUTE: begin
               na = (int'(ca) > SLOTS) ? SLOTS : int'(ca);
               nb = (int'(cb) > SLOTS) ? SLOTS : int'(cb);
               want.min_dist = DIST_ALL_ONES;
               want.found    = 1'b0;
               for (int i = 0; i < na; i++) begin
                  for (int j = 0; j < nb; j++) begin
                     d = pair_sq_distance(i, j);
                     if (d < want.min_dist) want.min_dist = d;
                     want.found = 1'b1;
                  end
               end
               expected_min_q.push_back(want);
               n_computes++;
               if (want.found) n_found++;
            end
            default: n_ignored++;
         endcase
      endfunction

      // Compare one accepted result with the oldest expectation
      function void check_result(logic [DIST_W-1:0] min_dist, logic found);
         min_result_type want;
         if (expected_min_q.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected result: min_distance=%0d pair_found=%0b",
                        min_dist, found);
            return;
         end
         want = expected_min_q.pop_front();
         if (min_dist !== want.min_dist || found !== want.found) begin
            failures++;
            if (failures <= 10)
               $display("result mismatch: expected %0d/%0b, got %0d/%0b",
                        want.min_dist, want.found, min_dist, found);
         end
      endfunction
   endclass
endpackage

module testbench;
   import mdsd_pkg::*;
   import mdsd_tb_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam int IDLE_PCT    = 22;
   localparam int QUIET_LIMIT = 20000;
   localparam int CFG_SETTLE  = 4;
   localparam int END_SETTLE  = 16;
   localparam int RANDOM_ITEMS = 80;

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_stall;
   logic [ACTION_W-1:0]  req_action       = '0;
   logic [SLOT_W-1:0]    req_slot         = '0;
   logic [ELEMENT_W-1:0] req_element      = '0;
   logic [VALUE_W-1:0]   req_value        = '0;
   logic [COUNT_W-1:0]   req_count_a      = '0;
   logic [COUNT_W-1:0]   req_count_b      = '0;
   logic                 rsp_valid;
   logic                 rsp_stall        = 1'b0;
   logic [DIST_W-1:0]    rsp_min_distance;
   logic                 rsp_pair_found;
   logic                 csr_write_enable = 1'b0;
   logic [DIST_W-1:0]    csr_write_data   = '0;

   logic steady = 1'b0;
   int   quiet_cycles = 0;
   logic [DIST_W-1:0] thresholds [5];
   min_distance_scoreboard sb;

   min_descriptor_set_distance u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_slot         (req_slot),
      .req_element      (req_element),
      .req_value        (req_value),
      .req_count_a      (req_count_a),
      .req_count_b      (req_count_b),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_min_distance (rsp_min_distance),
      .rsp_pair_found   (rsp_pair_found),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the result channel at random outside the steady stretch
   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
   end

   // Check results and end the run if nothing moves for too long
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_min_distance, rsp_pair_found);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: nothing accepted for %0d cycles", QUIET_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   function automatic logic [VALUE_W-1:0] random_value();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return VALUE_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Present one request, hold it until accepted, then maybe idle a little
   task automatic issue_request(input logic [ACTION_W-1:0] act,
                                input logic [SLOT_W-1:0] slot,
                                input logic [ELEMENT_W-1:0] elem,
                                input logic [VALUE_W-1:0] val,
                                input logic [COUNT_W-1:0] ca,
                                input logic [COUNT_W-1:0] cb);
      req_valid   <= 1'b1;
      req_action  <= act;
      req_slot    <= slot;
      req_element <= elem;
      req_value   <= val;
      req_count_a <= ca;
      req_count_b <= cb;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(act, slot, elem, val, ca, cb);
      if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
   endtask

   task automatic issue_compute(input int ca, input int cb);
      issue_request(ACT_COMPUTE, SLOT_W'($urandom_range(0, 3)),
                    ELEMENT_W'($urandom_range(0, 127)), random_value(),
                    COUNT_W'(ca), COUNT_W'(cb));
   endtask

   task automatic issue_load(input logic [ACTION_W-1:0] act, input int slot, input int elem,
                             input logic [VALUE_W-1:0] val);
      issue_request(act, SLOT_W'(slot), ELEMENT_W'(elem), val,
                    COUNT_W'($urandom_range(0, 7)), COUNT_W'($urandom_range(0, 7)));
   endtask

   // Drop valid and wait until every expected result has come back
   task automatic drain_results(input int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_min_q.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [DIST_W-1:0] t);
      drain_results(CFG_SETTLE);
      csr_write_enable <= 1'b1;
      csr_write_data   <= t;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_threshold(t);
   endtask

   // Write every element of both sets: slot 0 is the farthest pair,
   // the last slot holds an identical pair, the rest is random
   task automatic fill_stores();
      logic [VALUE_W-1:0] shared [DIM];
      foreach (shared[k]) shared[k] = random_value();
      for (int s = 0; s < SLOTS; s++) begin
         for (int k = 0; k < DIM; k++) begin
            issue_load(ACT_LOAD_A, s, k,
                       (s == 0) ? 8'hFF : (s == SLOTS-1) ? shared[k] : random_value());
         end
      end
      for (int s = 0; s < SLOTS; s++) begin
         for (int k = 0; k < DIM; k++) begin
            issue_load(ACT_LOAD_B, s, k,
                       (s == 0) ? 8'h00 : (s == SLOTS-1) ? shared[k] : random_value());
         end
      end
   endtask

   // Fixed pair counts: single pair, full sets, saturated counts, uneven sets
   task automatic probe_pairs();
      issue_compute(1, 1);
      issue_compute(SLOTS, SLOTS);
      issue_compute(7, 7);
      issue_compute(2, 5);
   endtask

   // Mostly element rewrites and computes, with a few ignored requests mixed in
   task automatic run_random(input int n);
      int done;
      int pick;
      done = 0;
      while (done < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            issue_compute($urandom_range(0, 7), $urandom_range(0, 7));
            done++;
         end else if (pick < 18) begin
            issue_request(ACT_UNUSED, SLOT_W'($urandom_range(0, 3)),
                          ELEMENT_W'($urandom_range(0, 127)), random_value(),
                          COUNT_W'($urandom_range(0, 7)), COUNT_W'($urandom_range(0, 7)));
         end else begin
            issue_load($urandom_range(0, 1) ? ACT_LOAD_B : ACT_LOAD_A,
                       $urandom_range(0, SLOTS-1), $urandom_range(0, DIM-1), random_value());
            done++;
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Empty sets, an ignored action and edge loads before any element is read
      issue_compute(0, 0);
      issue_compute(0, 7);
      issue_compute(4, 0);
      issue_compute(7, 0);
      issue_request(ACT_UNUSED, '1, '1, '1, '1, '1);
      issue_load(ACT_LOAD_A, SLOTS-1, DIM-1, 8'hFF);
      issue_load(ACT_LOAD_B, 0, 0, 8'h00);

      fill_stores();
      probe_pairs();
      run_random(RANDOM_ITEMS);

      // Walk the threshold through both extremes, a threshold of one and two random settings
      thresholds[0] = '0;
      thresholds[1] = DIST_W'(1);
      thresholds[2] = DIST_W'($urandom_range(1000, 300000));
      thresholds[3] = DIST_ALL_ONES;
      thresholds[4] = DIST_W'($urandom_range(0, 24'hFF_FFFF));
      for (int p = 0; p < 5; p++) begin
         write_threshold(thresholds[p]);
         steady = (p == 2);
         probe_pairs();
         run_random(RANDOM_ITEMS);
      end
      steady = 1'b0;

      drain_results(END_SETTLE);
      $display("Run covered %0d element loads and %0d distance computes (%0d with pairs),",
               sb.n_loads, sb.n_computes, sb.n_found);
      $display("plus %0d ignored requests, over six threshold settings; %0d failures.",
               sb.n_ignored, sb.failures);
      if (sb.failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/mdsd_pkg.sv
rtl/mdsd_ctrl.sv
rtl/mdsd_datapath.sv
rtl/min_descriptor_set_distance.sv
tb/testbench.sv
